// ----- hdl/lcrt_pkg.sv -----
package lcrt_pkg;

  // Field widths of the channel words
  localparam int VALUE_W = 10;
  localparam int RUN_W   = 11;

  // Default value range and the width of the set tag kept in each entry
  localparam int DEF_VALUE_BITS = 10;
  localparam int EPOCH_BITS     = 8;

  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last_of_set;
  } in_word_t;

  typedef struct packed {
    logic [RUN_W-1:0] max_run_length;
    logic             set_done;
  } out_word_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SELF,
    S_EVAL,
    S_WLO,
    S_WHI,
    S_DONE
  } lcrt_state_t;

endpackage

// ----- hdl/lcrt_ram.sv -----
module lcrt_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en_a,
  input  logic [AW-1:0]    rd_addr_a,
  output logic [WIDTH-1:0] rd_data_a,
  input  logic             rd_en_b,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered reads; data holds while the port is not enabled
  always_ff @(posedge clk) begin
    if (rd_en_a) begin
      rd_data_a_r <= mem_r[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_data_b_r <= mem_r[rd_addr_b];
    end
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

// ----- hdl/longest_consecutive_run_tracker_core.sv -----
// Channel  Dir  Word        Fields
// in_      in   in_word_t   value, last_of_set
// out_     out  out_word_t  max_run_length, set_done
//
// After acceptance a word passes the self lookup (S_SELF), the evaluation
// (S_EVAL, which also writes the value's own entry), a write state for each
// run end it touches (S_WLO, S_WHI), then the load, which waits until the
// output register is free. in_ready returns in the cycle after the load,
// even while that result waits for out_ready. After reset and after every
// 255th set, a sweep clears all 2^VALUE_BITS entries with in_ready low.
module longest_consecutive_run_tracker_core
  import lcrt_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int DEPTH = 1 << VALUE_BITS;
  localparam int LEN_W = VALUE_BITS + 1;
  localparam int ENT_W = EPOCH_BITS + VALUE_BITS;
  localparam int CMP_W = (LEN_W > RUN_W) ? LEN_W : RUN_W;

  localparam logic [VALUE_BITS-1:0] V_MAX       = '1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);

  // One memory word per value: the set tag marks it present in the current
  // set, the partner is the value at the other end of its run (valid only at
  // run ends, and only while the tag is current).
  typedef struct packed {
    logic [EPOCH_BITS-1:0] tag;
    logic [VALUE_BITS-1:0] partner;
  } ent_t;

  lcrt_state_t           state_r, state_nxt;
  logic [VALUE_BITS-1:0] clr_cnt_r;
  logic [EPOCH_BITS-1:0] epoch_r;
  logic [LEN_W-1:0]      best_r;
  logic                  out_valid_r;
  out_word_t             out_data_r;

  // Per-item payload
  logic [VALUE_BITS-1:0] v_r;
  logic                  last_r;
  ent_t                  lo_ent_r;
  logic                  has_lo_r, has_hi_r;
  logic [VALUE_BITS-1:0] lo_end_r, hi_end_r;

  // Memory ports
  logic                  wr_en;
  logic [VALUE_BITS-1:0] wr_addr;
  ent_t                  wr_ent;
  logic                  rd_en_a, rd_en_b;
  logic [VALUE_BITS-1:0] rd_addr_a, rd_addr_b;
  logic [ENT_W-1:0]      rd_data_a, rd_data_b;

  // Evaluation
  logic                  accept;
  logic                  out_free;
  logic [VALUE_BITS-1:0] v_in;
  ent_t                  self_ent, hi_ent;
  logic                  seen_v, has_lo, has_hi;
  logic [VALUE_BITS-1:0] lo_end, hi_end, span_lo, span_hi;
  logic [LEN_W-1:0]      run_len;
  logic [CMP_W-1:0]      best_ext;
  logic [RUN_W-1:0]      run_sat;
  logic                  set_end;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign v_in      = VALUE_BITS'(in_data.value);
  assign set_end   = (state_r == S_DONE) && out_free && last_r;

  // Lookups: both neighbors straight off the input word, then the value
  // itself. Port B is not re-read, so it still holds the upper neighbor
  // when the value's own entry comes back.
  assign rd_en_a   = accept || (state_r == S_SELF);
  assign rd_addr_a = (state_r == S_IDLE) ? (v_in - VALUE_BITS'(1)) : v_r;
  assign rd_en_b   = accept;
  assign rd_addr_b = v_in + VALUE_BITS'(1);

  lcrt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ent_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_ent),
    .rd_en_a   (rd_en_a),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_en_b   (rd_en_b),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  // Classify the new value; no wrap at the range edges
  always_comb begin
    self_ent = ent_t'(rd_data_a);
    hi_ent   = ent_t'(rd_data_b);
    seen_v   = (self_ent.tag == epoch_r);
    has_lo   = (v_r != '0) && (lo_ent_r.tag == epoch_r);
    has_hi   = (v_r != V_MAX) && (hi_ent.tag == epoch_r);
    lo_end   = lo_ent_r.partner;
    hi_end   = hi_ent.partner;
    span_lo  = has_lo ? lo_end : v_r;
    span_hi  = has_hi ? hi_end : v_r;
    run_len  = LEN_W'(span_hi) - LEN_W'(span_lo) + LEN_W'(1);
  end

  // Write port: sweep, then up to three partner updates per item
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = v_r;
    wr_ent  = '{tag: epoch_r, partner: v_r};
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_ent  = '{tag: '0, partner: '0};
      end
      S_EVAL: begin
        // A lone value or a bridging value points at itself
        wr_en = !seen_v;
        if (has_lo && !has_hi) begin
          wr_ent.partner = lo_end;
        end else if (has_hi && !has_lo) begin
          wr_ent.partner = hi_end;
        end
      end
      S_WLO: begin
        wr_en          = 1'b1;
        wr_addr        = lo_end_r;
        wr_ent.partner = has_hi_r ? hi_end_r : v_r;
      end
      S_WHI: begin
        wr_en          = 1'b1;
        wr_addr        = hi_end_r;
        wr_ent.partner = has_lo_r ? lo_end_r : v_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == V_MAX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SELF;
        end
      end
      S_SELF: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (seen_v) begin
          state_nxt = S_DONE;
        end else if (has_lo) begin
          state_nxt = S_WLO;
        end else if (has_hi) begin
          state_nxt = S_WHI;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WLO: begin
        state_nxt = has_hi_r ? S_WHI : S_DONE;
      end
      S_WHI: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register frees; sweep when the tags run out
        if (out_free) begin
          state_nxt = (last_r && (epoch_r == EPOCH_LAST)) ? S_CLEAR : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Saturate the reported length to the output field
  always_comb begin
    best_ext = CMP_W'(best_r);
    run_sat  = (best_ext > CMP_W'(RUN_MAX)) ? RUN_MAX : RUN_W'(best_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      epoch_r     <= EPOCH_FIRST;
      best_r      <= LEN_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + VALUE_BITS'(1);
      end
      // Advance the set tag; a stale tag never matches the live one
      if (set_end) begin
        epoch_r <= (epoch_r == EPOCH_LAST) ? EPOCH_FIRST : epoch_r + EPOCH_BITS'(1);
        best_r  <= LEN_W'(1);
      end else if ((state_r == S_EVAL) && !seen_v && (run_len > best_r)) begin
        best_r <= run_len;
      end
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_r    <= v_in;
      last_r <= in_data.last_of_set;
    end
    if (state_r == S_SELF) begin
      lo_ent_r <= ent_t'(rd_data_a);
    end
    if (state_r == S_EVAL) begin
      has_lo_r <= has_lo;
      has_hi_r <= has_hi;
      lo_end_r <= lo_end;
      hi_end_r <= hi_end;
    end
    if ((state_r == S_DONE) && out_free) begin
      out_data_r.max_run_length <= run_sat;
      out_data_r.set_done       <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SELF))
    else $error("accepted word did not enter lookup");

  a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    best_r != '0)
    else $error("best run length dropped to zero");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside of completion");

  a_live_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |-> (epoch_r != '0))
    else $error("live set tag equals the swept tag");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CLEAR) && (clr_cnt_r == V_MAX)) |=>
      ((state_r == S_IDLE) && (clr_cnt_r == '0)))
    else $error("sweep did not finish cleanly");
`endif

endmodule

// ----- tb/sv/longest_consecutive_run_tracker_core_tb.sv -----
module longest_consecutive_run_tracker_core_tb;
  import lcrt_pkg::*;

  localparam int TABLE_SIZE  = 1 << DEF_VALUE_BITS;
  localparam int IDLE_LIMIT  = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 30;
  localparam int ITEM_TARGET = 550;

  // Tracks runs of consecutive values per set and keeps the expected result words.
  class run_length_scoreboard;
    bit                       present[TABLE_SIZE];
    int unsigned              end_of_run[TABLE_SIZE];
    int unsigned              longest;
    out_word_t                expected_words[$];
    int                       errors;

    function new();
      foreach (present[i]) begin
        present[i]    = 1'b0;
        end_of_run[i] = 0;
      end
      longest = 1;
      errors  = 0;
    endfunction

    function void offer(int unsigned len);
      if (len > longest) longest = len;
    endfunction

    // Apply one accepted word to the run tables and queue the word it should produce.
    function void track_value(in_word_t w);
      int unsigned v, lo_end, hi_end;
      bit          has_lo, has_hi;
      out_word_t   res;
      v = w.value & (TABLE_SIZE - 1);
      if (!present[v]) begin
        has_lo = (v > 0) && present[v-1];
        has_hi = (v < TABLE_SIZE - 1) && present[v+1];
        present[v] = 1'b1;
        if (!has_lo && !has_hi) begin
          end_of_run[v] = v;
        end else if (!has_lo) begin
          hi_end = end_of_run[v+1];
          end_of_run[v]      = hi_end;
          end_of_run[hi_end] = v;
          offer(hi_end - v + 1);
        end else if (!has_hi) begin
          lo_end = end_of_run[v-1];
          end_of_run[v]      = lo_end;
          end_of_run[lo_end] = v;
          offer(v - lo_end + 1);
        end else begin
          lo_end = end_of_run[v-1];
          hi_end = end_of_run[v+1];
          end_of_run[v]      = v;
          end_of_run[lo_end] = hi_end;
          end_of_run[hi_end] = lo_end;
          offer(hi_end - lo_end + 1);
        end
      end
      res.max_run_length = (longest > RUN_MAX) ? RUN_MAX : longest[RUN_W-1:0];
      res.set_done       = w.last_of_set;
      expected_words.push_back(res);
      if (w.last_of_set) begin
        foreach (present[i]) present[i] = 1'b0;
        longest = 1;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with nothing expected: max_run_length %0d set_done %0b",
                 $time, got.max_run_length, got.set_done);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.max_run_length !== exp_w.max_run_length) begin
        $display("%0t: max_run_length expected %0d got %0d",
                 $time, exp_w.max_run_length, got.max_run_length);
        errors++;
      end
      if (got.set_done !== exp_w.set_done) begin
        $display("%0t: set_done expected %0b got %0b", $time, exp_w.set_done, got.set_done);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  run_length_scoreboard sb = new();

  logic hold_req   = 1'b0;
  bit   hold_done  = 1'b0;
  int   burst_left = 0;
  int   sent_items = 0;
  int   idle_count = 0;

  longest_consecutive_run_tracker_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one word, hold it until accepted, then maybe open a gap before the next.
  task automatic push_value(input int v, input bit last);
    in_word_t w;
    int       gap;
    w.value       = v[VALUE_W-1:0];
    w.last_of_set = last;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.track_value(w);
    sent_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      in_data  <= '{value: VALUE_W'($urandom), last_of_set: 1'($urandom)};
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
    end
  endtask

  // Receiver: switch among random stall patterns, with one long hold-off on request.
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= (cyc % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
  end

  // Give up when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int n, w, base, v, pick, k;
    int set_vals[$];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Both ends of the range, join from each side, merge of two runs, repeats.
    push_value(0, 0);
    push_value(1023, 0);
    push_value(1, 0);
    push_value(1022, 0);
    push_value(5, 0);
    push_value(3, 0);
    push_value(4, 0);
    push_value(4, 0);
    push_value(2, 0);
    push_value(1021, 1);
    // One-word set.
    push_value(512, 1);
    push_value(7, 0);
    push_value(9, 0);
    push_value(8, 0);
    push_value(10, 0);
    push_value(6, 0);
    push_value(9, 0);
    push_value(11, 1);
    // Values from an earlier set must not count again.
    push_value(1023, 0);
    push_value(0, 1);

    // Many tiny sets: walk the set tag past its wrap so the periodic sweep runs.
    repeat (260) begin
      v = $urandom_range(0, TABLE_SIZE - 1);
      if ($urandom_range(0, 4) == 0) begin
        push_value(v, 0);
        pick = $urandom_range(0, 2);
        push_value((pick == 0) ? v : (pick == 1) ? ((v + 1) % TABLE_SIZE)
                                                 : ((v + TABLE_SIZE - 1) % TABLE_SIZE), 1);
      end else begin
        push_value(v, 1);
      end
    end

    // Well-formed sets packed into narrow windows so runs grow, join and merge.
    while (sent_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) n = $urandom_range(1, 2);
      else if (pick < 7) n = $urandom_range(3, 12);
      else n = $urandom_range(13, 40);
      w = $urandom_range(n / 2 + 1, 2 * n);
      pick = $urandom_range(0, 19);
      if (pick < 3) base = 0;
      else if (pick < 6) base = TABLE_SIZE - w;
      else base = $urandom_range(0, TABLE_SIZE - w);
      set_vals.delete();
      for (k = 0; k < n; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 2 && set_vals.size() > 0)
          v = set_vals[$urandom_range(0, set_vals.size() - 1)];
        else if (pick == 2)
          v = $urandom_range(0, TABLE_SIZE - 1);
        else
          v = base + $urandom_range(0, w - 1);
        set_vals.push_back(v);
        push_value(v, k == n - 1);
        if (!hold_req && sent_items > 380) hold_req <= 1'b1;
      end
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/lcrt_pkg.sv
hdl/lcrt_ram.sv
hdl/longest_consecutive_run_tracker_core.sv
tb/sv/longest_consecutive_run_tracker_core_tb.sv
